@@ hw/rtl/pal_pkg.sv @@
// Shared types, codes and widths for the positional array list unit.
`timescale 1ns / 1ps

package pal_pkg;

    localparam int DEF_LIST_DEPTH = 128;
    localparam int REQ_W          = 2;
    localparam int POS_W          = 7;
    localparam int VAL_W          = 32;
    localparam int MOV_W          = 7;
    localparam int LEN_W          = 8;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_READ   = 2'd2
    } pal_req_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } pal_status_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_DELETE,
        OP_READ
    } pal_op_t;

    typedef struct packed {
        pal_op_t     op;
        pal_status_t status;
    } pal_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_MOVE_RD,
        S_MOVE_WR,
        S_PUT,
        S_DONE
    } pal_state_t;

    function automatic int pal_cmd_w(input int depth);
        return $bits(pal_ctl_t) + 2 * $clog2(depth) + LEN_W + VAL_W;
    endfunction

endpackage

@@ hw/rtl/pal_front.sv @@
// Request front end: accepts words, checks them against the length and queues commands.
`timescale 1ns / 1ps

module pal_front import pal_pkg::*; #(
    parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [REQ_W-1:0]                     s_req_type,
    input  logic [POS_W-1:0]                     s_position,
    input  logic signed [VAL_W-1:0]              s_value,
    input  logic                                 q_full,
    output logic                                 q_push,
    output logic [pal_cmd_w(LIST_DEPTH)-1:0]     q_data
);

    localparam int IW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] new_cnt;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] moves_x;
    pal_ctl_t      ctl;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;
    assign pos_x   = XW'(s_position);
    assign cnt_x   = XW'(count_reg);

    always_comb begin
        ctl.op     = OP_NONE;
        ctl.status = ST_DONE;
        moves_x    = '0;
        new_cnt    = count_reg;
        case (s_req_type)
            REQ_INSERT: begin
                if (cnt_x == XW'(LIST_DEPTH)) begin
                    ctl.status = ST_FULL;
                end else if (pos_x > cnt_x) begin
                    ctl.status = ST_RANGE;
                end else begin
                    ctl.op  = OP_INSERT;
                    moves_x = cnt_x - pos_x;
                    new_cnt = count_reg + CW'(1);
                end
            end
            REQ_DELETE: begin
                if (pos_x >= cnt_x) begin
                    ctl.status = ST_RANGE;
                end else begin
                    ctl.op  = OP_DELETE;
                    moves_x = cnt_x - pos_x - XW'(1);
                    new_cnt = count_reg - CW'(1);
                end
            end
            REQ_READ: begin
                if (pos_x >= cnt_x) begin
                    ctl.status = ST_RANGE;
                end else begin
                    ctl.op = OP_READ;
                end
            end
            default: begin
            end
        endcase
        count_next = q_push ? new_cnt : count_reg;
    end

    assign q_data = {ctl, IW'(pos_x), IW'(moves_x), LEN_W'(new_cnt), s_value};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(LIST_DEPTH))
        else $error("list length beyond depth");

endmodule

@@ hw/rtl/pal_queue.sv @@
// Two-entry command queue between front end and back end.
`timescale 1ns / 1ps

module pal_queue #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output logic [DATA_W-1:0] head_data
);

    logic [DATA_W-1:0] slot_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        fill_reg;
    logic [1:0]        fill_next;
    logic              do_push;
    logic              do_pop;

    assign full       = fill_reg == 2'd2;
    assign head_valid = fill_reg != 2'd0;
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

@@ hw/rtl/pal_back.sv @@
// Command back end: entry memory, shift sequencer and result register.
`timescale 1ns / 1ps

module pal_back import pal_pkg::*; #(
    parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    input  logic [pal_cmd_w(LIST_DEPTH)-1:0] q_data,
    output logic                             q_pop,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_status,
    output logic signed [VAL_W-1:0]          m_item,
    output logic [MOV_W-1:0]                 m_moves,
    output logic [LEN_W-1:0]                 m_length
);

    localparam int IW = $clog2(LIST_DEPTH);

    pal_ctl_t          h_ctl;
    logic [IW-1:0]     h_pos;
    logic [IW-1:0]     h_moves;
    logic [LEN_W-1:0]  h_len;
    logic [VAL_W-1:0]  h_val;

    logic [VAL_W-1:0]  mem [LIST_DEPTH];
    logic [VAL_W-1:0]  rd_data_reg;
    logic [IW-1:0]     rd_addr;
    logic [IW-1:0]     wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic              mem_we;

    pal_state_t        state_reg, state_next;
    pal_ctl_t          ctl_reg, ctl_next;
    logic [IW-1:0]     pos_reg, pos_next;
    logic [IW-1:0]     src_reg, src_next;
    logic [IW-1:0]     rem_reg, rem_next;
    logic [IW-1:0]     moves_reg, moves_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [VAL_W-1:0]  item_reg, item_next;

    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_status_reg, m_status_next;
    logic [VAL_W-1:0]  m_item_reg, m_item_next;
    logic [MOV_W-1:0]  m_moves_reg, m_moves_next;
    logic [LEN_W-1:0]  m_length_reg, m_length_next;
    logic              out_free;

    assign {h_ctl, h_pos, h_moves, h_len, h_val} = q_data;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        ctl_next      = ctl_reg;
        pos_next      = pos_reg;
        src_next      = src_reg;
        rem_next      = rem_reg;
        moves_next    = moves_reg;
        len_next      = len_reg;
        val_next      = val_reg;
        item_next     = item_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        wr_addr       = pos_reg;
        wr_data       = val_reg;
        rd_addr       = (state_reg == S_IDLE) ? h_pos : src_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_item_next   = m_item_reg;
        m_moves_next  = m_moves_reg;
        m_length_next = m_length_reg;
        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    ctl_next   = h_ctl;
                    pos_next   = h_pos;
                    rem_next   = h_moves;
                    moves_next = h_moves;
                    len_next   = h_len;
                    val_next   = h_val;
                    item_next  = '0;
                    src_next   = h_pos + h_moves - IW'(1);
                    case (h_ctl.op)
                        OP_INSERT: state_next = (h_moves == '0) ? S_PUT : S_MOVE_RD;
                        OP_DELETE: state_next = S_FETCH;
                        OP_READ:   state_next = S_FETCH;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_FETCH: begin
                item_next = rd_data_reg;
                src_next  = pos_reg + IW'(1);
                if (ctl_reg.op == OP_DELETE && rem_reg != '0) begin
                    state_next = S_MOVE_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_MOVE_RD: begin
                state_next = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                mem_we   = 1'b1;
                wr_data  = rd_data_reg;
                rem_next = rem_reg - IW'(1);
                if (ctl_reg.op == OP_INSERT) begin
                    wr_addr  = src_reg + IW'(1);
                    src_next = src_reg - IW'(1);
                end else begin
                    wr_addr  = src_reg - IW'(1);
                    src_next = src_reg + IW'(1);
                end
                if (rem_reg == IW'(1)) begin
                    state_next = (ctl_reg.op == OP_INSERT) ? S_PUT : S_DONE;
                end else begin
                    state_next = S_MOVE_RD;
                end
            end
            S_PUT: begin
                mem_we     = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = val_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = ctl_reg.status;
                    m_item_next   = item_reg;
                    m_moves_next  = MOV_W'(moves_reg);
                    m_length_next = len_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        ctl_reg      <= ctl_next;
        pos_reg      <= pos_next;
        src_reg      <= src_next;
        rem_reg      <= rem_next;
        moves_reg    <= moves_next;
        len_reg      <= len_next;
        val_reg      <= val_next;
        item_reg     <= item_next;
        m_status_reg <= m_status_next;
        m_item_reg   <= m_item_next;
        m_moves_reg  <= m_moves_next;
        m_length_reg <= m_length_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_item   = m_item_reg;
    assign m_moves  = m_moves_reg;
    assign m_length = m_length_reg;

    a_rem_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MOVE_RD || state_reg == S_MOVE_WR) |-> rem_reg != '0)
        else $error("shift running with no entries left");

    a_rd_then_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MOVE_RD |=> state_reg == S_MOVE_WR)
        else $error("shift read not followed by write");

    a_we_op: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (ctl_reg.op == OP_INSERT || ctl_reg.op == OP_DELETE))
        else $error("memory written by a non-modifying command");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && out_free && ctl_reg.status != ST_DONE)
        |=> (m_valid && m_item == '0 && m_moves == '0))
        else $error("rejected command returned data");

endmodule

@@ hw/rtl/positional_array_list_unit.sv @@
// Positional array list: insert, delete and read at a position in an ordered list.
// A rejected request or an unknown kind goes straight to the result; a read fetches its entry;
// insert shifts entries from the position up, then writes the new one; delete fetches its
// entry and shifts later ones down. The entry memory sequencer runs one request at
// a time and moves one entry per read/write pair; a two-word queue takes requests meanwhile.
// Reset clears the length, the queue and the output register; list contents are not cleared.
`timescale 1ns / 1ps

module positional_array_list_unit import pal_pkg::*; #(
    parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [REQ_W-1:0]        s_req_type,
    input  logic [POS_W-1:0]        s_position,
    input  logic signed [VAL_W-1:0] s_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_status,
    output logic signed [VAL_W-1:0] m_item,
    output logic [MOV_W-1:0]        m_moves,
    output logic [LEN_W-1:0]        m_length
);

    localparam int CMD_W = pal_cmd_w(LIST_DEPTH);

    logic             q_full;
    logic             q_push;
    logic [CMD_W-1:0] q_in;
    logic             q_pop;
    logic             q_valid;
    logic [CMD_W-1:0] q_out;

    pal_front #(.LIST_DEPTH(LIST_DEPTH)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_position (s_position),
        .s_value    (s_value),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    pal_queue #(.DATA_W(CMD_W)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_out)
    );

    pal_back #(.LIST_DEPTH(LIST_DEPTH)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status),
        .m_item   (m_item),
        .m_moves  (m_moves),
        .m_length (m_length)
    );

endmodule

@@ verif/positional_array_list_unit_tb.sv @@
// Self-checking bench for the positional array list unit: list tracker, request driver, result checker.
`timescale 1ns / 1ps

import pal_pkg::*;

typedef struct {
    pal_status_t             status;
    logic signed [VAL_W-1:0] item;
    logic [MOV_W-1:0]        moves;
    logic [LEN_W-1:0]        length;
} pal_response_t;

class pal_list_tracker;
    logic signed [VAL_W-1:0] cells [DEF_LIST_DEPTH];
    int unsigned             count;
    int unsigned             errors;
    pal_response_t           pending_responses [$];

    function new();
        count  = 0;
        errors = 0;
    endfunction

    function void note_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                               input logic signed [VAL_W-1:0] val);
        pal_response_t rsp;
        int unsigned   p;
        int unsigned   i;
        rsp.status = ST_DONE;
        rsp.item   = '0;
        rsp.moves  = '0;
        p = pos;
        case (kind)
            REQ_INSERT: begin
                if (count >= DEF_LIST_DEPTH) begin
                    rsp.status = ST_FULL;
                end else if (p > count) begin
                    rsp.status = ST_RANGE;
                end else begin
                    for (i = count; i > p; i--)
                        cells[i] = cells[i - 1];
                    cells[p]  = val;
                    rsp.moves = MOV_W'(count - p);
                    count++;
                end
            end
            REQ_DELETE: begin
                if (p >= count) begin
                    rsp.status = ST_RANGE;
                end else begin
                    rsp.item = cells[p];
                    for (i = p; i + 1 < count; i++)
                        cells[i] = cells[i + 1];
                    rsp.moves = MOV_W'(count - 1 - p);
                    count--;
                end
            end
            REQ_READ: begin
                if (p >= count)
                    rsp.status = ST_RANGE;
                else
                    rsp.item = cells[p];
            end
            default: ;
        endcase
        rsp.length = LEN_W'(count);
        pending_responses.push_back(rsp);
    endfunction

    function void check_response(input logic [1:0] status, input logic signed [VAL_W-1:0] item,
                                 input logic [MOV_W-1:0] moves, input logic [LEN_W-1:0] length);
        pal_response_t exp;
        if (pending_responses.size() == 0) begin
            $error("result word with no request outstanding");
            errors++;
            return;
        end
        exp = pending_responses.pop_front();
        if (status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, status);
            errors++;
        end
        if (item !== exp.item) begin
            $error("item: expected %0d, got %0d", exp.item, item);
            errors++;
        end
        if (moves !== exp.moves) begin
            $error("moves: expected %0d, got %0d", exp.moves, moves);
            errors++;
        end
        if (length !== exp.length) begin
            $error("length: expected %0d, got %0d", exp.length, length);
            errors++;
        end
    endfunction
endclass

module positional_array_list_unit_tb;

    localparam logic [REQ_W-1:0] REQ_IGNORED  = 2'd3;
    localparam int               RANDOM_ITEMS = 1100;

    typedef enum int {
        MODE_FILL,
        MODE_MIXED,
        MODE_DRAIN
    } mix_mode_t;

    logic                    aclk       = 1'b0;
    logic                    aresetn    = 1'b0;
    logic                    s_valid    = 1'b0;
    logic                    s_ready;
    logic [REQ_W-1:0]        s_req_type = '0;
    logic [POS_W-1:0]        s_position = '0;
    logic signed [VAL_W-1:0] s_value    = '0;
    logic                    m_valid;
    logic                    m_ready    = 1'b0;
    logic [1:0]              m_status;
    logic signed [VAL_W-1:0] m_item;
    logic [MOV_W-1:0]        m_moves;
    logic [LEN_W-1:0]        m_length;

    int                      ready_hold = 0;
    pal_list_tracker         tracker    = new();

    positional_array_list_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_position (s_position),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_item     (m_item),
        .m_moves    (m_moves),
        .m_length   (m_length)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic int unsigned pick_gap(input bit gaps_on);
        int unsigned r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(input logic [REQ_W-1:0] kind, input int unsigned pos,
                                input logic signed [VAL_W-1:0] val, input int unsigned gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= kind;
        s_position <= POS_W'(pos);
        s_value    <= val;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request(kind, POS_W'(pos), val);
    endtask

    task automatic issue_random(input mix_mode_t mode, input bit gaps_on);
        int unsigned      r;
        int unsigned      q;
        int unsigned      cnt;
        int unsigned      top;
        int unsigned      pos;
        logic [REQ_W-1:0] kind;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:  kind = r < 88 ? REQ_INSERT : r < 93 ? REQ_DELETE :
                               r < 98 ? REQ_READ : REQ_IGNORED;
            MODE_DRAIN: kind = r < 8 ? REQ_INSERT : r < 88 ? REQ_DELETE :
                               r < 97 ? REQ_READ : REQ_IGNORED;
            default:    kind = r < 40 ? REQ_INSERT : r < 75 ? REQ_DELETE :
                               r < 95 ? REQ_READ : REQ_IGNORED;
        endcase
        cnt = tracker.count;
        top = (kind == REQ_INSERT) ? cnt : (cnt > 0 ? cnt - 1 : 0);
        if (top > 127)
            top = 127;
        q = $urandom_range(0, 9);
        if (q == 0 || kind == REQ_IGNORED || (kind != REQ_INSERT && cnt == 0))
            pos = $urandom_range(0, 127);
        else if (q == 1)
            pos = 0;
        else if (q == 2)
            pos = top;
        else
            pos = $urandom_range(0, top);
        send_request(kind, pos, $urandom, pick_gap(gaps_on));
    endtask

    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    m_ready    <= 1'b1;
                    ready_hold <= $urandom_range(0, 20);
                end
                9: begin
                    m_ready    <= 1'b0;
                    ready_hold <= $urandom_range(8, 40);
                end
                default: begin
                    m_ready    <= 1'b0;
                    ready_hold <= $urandom_range(0, 2);
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_response(m_status, m_item, m_moves, m_length);
    end

    initial begin
        int unsigned sent;
        int unsigned seg;
        int unsigned len;
        bit          gaps_on;
        mix_mode_t   mode;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_request(REQ_READ,    0,   $urandom,        pick_gap(1));
        send_request(REQ_DELETE,  0,   $urandom,        pick_gap(1));
        send_request(REQ_INSERT,  1,   $urandom,        pick_gap(1));
        send_request(REQ_INSERT,  0,   32'sh8000_0000,  pick_gap(1));
        send_request(REQ_INSERT,  1,   32'sh7fff_ffff,  pick_gap(1));
        send_request(REQ_INSERT,  0,   -32'sd1,         pick_gap(1));
        send_request(REQ_INSERT,  1,   32'sd0,          pick_gap(1));
        send_request(REQ_READ,    0,   $urandom,        pick_gap(1));
        send_request(REQ_READ,    1,   $urandom,        pick_gap(1));
        send_request(REQ_READ,    2,   $urandom,        pick_gap(1));
        send_request(REQ_READ,    3,   $urandom,        pick_gap(1));
        send_request(REQ_READ,    4,   $urandom,        pick_gap(1));
        send_request(REQ_READ,    127, $urandom,        pick_gap(1));
        send_request(REQ_IGNORED, 127, 32'shffff_ffff,  pick_gap(1));
        send_request(REQ_INSERT,  127, $urandom,        pick_gap(1));
        send_request(REQ_DELETE,  127, $urandom,        pick_gap(1));
        send_request(REQ_DELETE,  1,   $urandom,        pick_gap(1));
        send_request(REQ_DELETE,  2,   $urandom,        pick_gap(1));
        send_request(REQ_DELETE,  0,   $urandom,        pick_gap(1));
        send_request(REQ_READ,    0,   $urandom,        pick_gap(1));
        send_request(REQ_DELETE,  0,   $urandom,        pick_gap(1));
        send_request(REQ_DELETE,  0,   $urandom,        pick_gap(1));
        send_request(REQ_IGNORED, 0,   32'sd0,          pick_gap(1));

        sent = 0;
        seg  = 0;
        while (sent < RANDOM_ITEMS) begin
            case (seg % 4)
                0:       mode = MODE_FILL;
                2:       mode = MODE_DRAIN;
                default: mode = MODE_MIXED;
            endcase
            len     = $urandom_range(120, 200);
            if (len > RANDOM_ITEMS - sent)
                len = RANDOM_ITEMS - sent;
            gaps_on = $urandom_range(0, 2) != 0;
            repeat (len) issue_random(mode, gaps_on);
            sent += len;
            seg++;
        end
        s_valid <= 1'b0;

        while (tracker.pending_responses.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (tracker.errors == 0)
            $display("positional_array_list_unit_tb: done, clean");
        else
            $display("positional_array_list_unit_tb: done, errors");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("positional_array_list_unit_tb: done, errors");
        $finish;
    end

endmodule

@@ positional_array_list_unit.f @@
hw/rtl/pal_pkg.sv
hw/rtl/pal_front.sv
hw/rtl/pal_queue.sv
hw/rtl/pal_back.sv
hw/rtl/positional_array_list_unit.sv
verif/positional_array_list_unit_tb.sv
